### src/assert_macros.svh
// Assertion macros included by the FFT top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error("lbl");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("lbl");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/wfft_pkg.sv
// Types and constants of the windowed FFT block.
`timescale 1ns / 1ps
package wfft_pkg;

    localparam int LOG2_POINTS_DEF       = 10;
    localparam int TWIDDLE_FRAC_BITS_DEF = 31;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_SKIP = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         point_index;
        logic signed [15:0] sample;
        logic [31:0]        window_weight;
    } item_t;

    typedef struct packed {
        logic signed [31:0] bin_real;
        logic signed [31:0] bin_imag;
        logic [9:0]         bin_number;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN_RD,
        ST_RUN_MUL,
        ST_RUN_ADD,
        ST_RUN_WT,
        ST_RUN_WB,
        ST_READ_REQ,
        ST_READ_DAT
    } state_t;

endpackage

### src/wfft_tw_rom.sv
// Twiddle factor ROM, built at elaboration, with a registered read.
`timescale 1ns / 1ps
module wfft_tw_rom #(
    parameter int LOG2_POINTS       = wfft_pkg::LOG2_POINTS_DEF,
    parameter int TWIDDLE_FRAC_BITS = wfft_pkg::TWIDDLE_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic [LOG2_POINTS-2:0] addr,
    output logic [31:0]            tw_re,
    output logic [31:0]            tw_im
);
    import wfft_pkg::*;

    localparam int HALF    = 1 << (LOG2_POINTS - 1);
    localparam int QUARTER = 1 << (LOG2_POINTS - 2);
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

    typedef logic [63:0] rom_t [HALF];

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [31:0] round_q(input logic [63:0] v);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] r;
        neg = v[63];
        mag = neg ? (~v + 64'd1) : v;
        r = (mag + (64'd1 << (61 - TWIDDLE_FRAC_BITS))) >> (62 - TWIDDLE_FRAC_BITS);
        if (!neg)
        begin
            return (r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
        end
        if (r > 64'h80000000)
        begin
            r = 64'h80000000;
        end
        return 32'd0 - r[31:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t         rom;
        logic [127:0] px;
        logic [63:0]  x;
        logic [63:0]  term;
        logic [63:0]  cc;
        logic [63:0]  ss;
        logic [63:0]  kk;
        for (int k = 0; k < HALF; k++)
        begin
            kk = (k < QUARTER) ? 64'(k) : 64'(k - QUARTER);
            px = {64'd0, PI_Q62} * {64'd0, kk};
            x = 64'(px >> (LOG2_POINTS - 1));
            term = 64'd1 << 62;
            cc = 64'd1 << 62;
            ss = 64'd0;
            for (int n = 1; n <= 30; n++)
            begin
                term = q62_mul(term, x) / 64'(n);
                if ((n % 2) == 1)
                begin
                    ss = (((n / 2) % 2) == 1) ? ss - term : ss + term;
                end
                else
                begin
                    cc = (((n / 2) % 2) == 1) ? cc - term : cc + term;
                end
            end
            if (k < QUARTER)
            begin
                rom[k] = {round_q(cc), round_q(64'd0 - ss)};
            end
            else
            begin
                rom[k] = {round_q(64'd0 - ss), round_q(64'd0 - cc)};
            end
        end
        return rom;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [63:0] word_reg;

    always_ff @(posedge clk)
    begin
        word_reg <= ROM[addr];
    end

    assign tw_re = word_reg[63:32];
    assign tw_im = word_reg[31:0];

endmodule

### src/windowed_radix2_fft_1024.sv
// Top level of the windowed radix-2 FFT with its point memory and sequencer.
//
//  channel | valid        | stall        | payload
//  item    | item_valid   | item_stall   | item   (wfft_pkg::item_t)
//  result  | result_valid | result_stall | result (wfft_pkg::result_t)
//
// Loads write in ST_LOAD; reads use ST_READ_REQ and wait in ST_READ_DAT for the result register.
// A run does (N/2)*LOG2_POINTS butterflies, each through states ST_RUN_RD to ST_RUN_WB.
// Each butterfly reads, multiplies, adds and writes back its two points in turn, without overlap.
// Reset clears control state only; the point memory holds no reset value.
// A waiting result does not hold off new items until a second read needs it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module windowed_radix2_fft_1024 #(
    parameter int LOG2_POINTS       = wfft_pkg::LOG2_POINTS_DEF,
    parameter int TWIDDLE_FRAC_BITS = wfft_pkg::TWIDDLE_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  wfft_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output wfft_pkg::result_t result
);
    import wfft_pkg::*;

    localparam int L    = LOG2_POINTS;
    localparam int NPTS = 1 << L;
    localparam int SW   = $clog2(L);

    logic [63:0] mem [NPTS];

    state_t state_reg, state_next;
    item_t  in_reg;
    logic [L-1:0]  idx;
    logic [L-1:0]  rev;
    logic [SW-1:0] st_reg;
    logic [L-2:0]  bf_reg;
    logic          last_bf;

    logic [63:0] rda_reg, rdb_reg;
    logic        rd_en;
    logic [L-1:0] addr_a, addr_b;
    logic        we;
    logic [L-1:0] waddr;
    logic [63:0] wdata;

    logic [L-1:0] jx, maskx, top, bot;
    logic [L-2:0] tw_addr;
    logic [31:0]  tw_re, tw_im;

    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [63:0] top_val_reg, bot_val_reg;
    logic signed [48:0] load_prod;

    logic    out_free;
    result_t out_reg;
    logic    out_valid_reg;

    assign idx = L'({22'd0, in_reg.point_index});
    always_comb
    begin
        for (int b = 0; b < L; b++)
        begin
            rev[L-1-b] = idx[b];
        end
    end

    assign jx      = {1'b0, bf_reg};
    assign maskx   = ~({L{1'b1}} << st_reg);
    assign top     = ((jx & ~maskx) << 1) | (jx & maskx);
    assign bot     = top | (L'(1) << st_reg);
    assign tw_addr = (bf_reg & maskx[L-2:0]) << ((L - 1) - int'(st_reg));
    assign last_bf = (&bf_reg) && (st_reg == SW'(L - 1));

    wfft_tw_rom #(
        .LOG2_POINTS(LOG2_POINTS),
        .TWIDDLE_FRAC_BITS(TWIDDLE_FRAC_BITS)
    ) u_tw_rom (
        .clk  (clk),
        .addr (tw_addr),
        .tw_re(tw_re),
        .tw_im(tw_im)
    );

    assign load_prod = in_reg.sample * $signed({1'b0, in_reg.window_weight});
    assign out_free  = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.mode)
                        MODE_LOAD: state_next = ST_LOAD;
                        MODE_RUN:  state_next = ST_RUN_RD;
                        MODE_READ: state_next = ST_READ_REQ;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:     state_next = ST_IDLE;
            ST_RUN_RD:   state_next = ST_RUN_MUL;
            ST_RUN_MUL:  state_next = ST_RUN_ADD;
            ST_RUN_ADD:  state_next = ST_RUN_WT;
            ST_RUN_WT:   state_next = ST_RUN_WB;
            ST_RUN_WB:   state_next = last_bf ? ST_IDLE : ST_RUN_RD;
            ST_READ_REQ: state_next = ST_READ_DAT;
            ST_READ_DAT: state_next = out_free ? ST_IDLE : ST_READ_DAT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        rd_en  = 1'b0;
        addr_a = top;
        addr_b = bot;
        we     = 1'b0;
        waddr  = top;
        wdata  = top_val_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                we    = 1'b1;
                waddr = rev;
                wdata = {load_prod[46:15], 32'd0};
            end
            ST_RUN_RD:
            begin
                rd_en = 1'b1;
            end
            ST_RUN_WT:
            begin
                we = 1'b1;
            end
            ST_RUN_WB:
            begin
                we    = 1'b1;
                waddr = bot;
                wdata = bot_val_reg;
            end
            ST_READ_REQ:
            begin
                rd_en  = 1'b1;
                addr_a = idx;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rda_reg <= mem[addr_a];
            rdb_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [63:0] prr, pii, pri, pir;
        logic [31:0] pr, pi;
        prr = $signed(rdb_reg[63:32]) * $signed(tw_re);
        pii = $signed(rdb_reg[31:0]) * $signed(tw_im);
        pri = $signed(rdb_reg[63:32]) * $signed(tw_im);
        pir = $signed(rdb_reg[31:0]) * $signed(tw_re);
        pr = 32'(p_rr_reg - p_ii_reg);
        pi = 32'(p_ri_reg + p_ir_reg);
        if (state_reg == ST_RUN_MUL)
        begin
            p_rr_reg <= prr[TWIDDLE_FRAC_BITS +: 32];
            p_ii_reg <= pii[TWIDDLE_FRAC_BITS +: 32];
            p_ri_reg <= pri[TWIDDLE_FRAC_BITS +: 32];
            p_ir_reg <= pir[TWIDDLE_FRAC_BITS +: 32];
        end
        if (state_reg == ST_RUN_ADD)
        begin
            top_val_reg <= {rda_reg[63:32] + pr, rda_reg[31:0] + pi};
            bot_val_reg <= {rda_reg[63:32] - pr, rda_reg[31:0] - pi};
        end
        if (state_reg == ST_IDLE && item_valid)
        begin
            in_reg <= item;
        end
        if (state_reg == ST_READ_DAT && out_free)
        begin
            out_reg.bin_real   <= rda_reg[63:32];
            out_reg.bin_imag   <= rda_reg[31:0];
            out_reg.bin_number <= 10'(idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            st_reg        <= '0;
            bf_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RUN_WB)
            begin
                bf_reg <= bf_reg + 1'b1;
                if (&bf_reg)
                begin
                    st_reg <= last_bf ? '0 : st_reg + 1'b1;
                end
            end
            if (state_reg == ST_READ_DAT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ASSERT_ALWAYS(a_stage_range, clk, rst_n, st_reg <= SW'(L - 1))
    `ASSERT_NEXT(a_run_ends, clk, rst_n, state_reg == ST_RUN_WB && last_bf, state_reg == ST_IDLE)
    `ASSERT_IMPL(a_result_source, clk, rst_n, $rose(result_valid), $past(state_reg) == ST_READ_DAT)
    `ASSERT_IMPL(a_write_states, clk, rst_n, we, state_reg == ST_LOAD || state_reg == ST_RUN_WT || state_reg == ST_RUN_WB)

endmodule

### verif/fft_bin_checker.sv
// Checker that predicts and compares the bins returned by the windowed FFT.
`timescale 1ns / 1ps
module fft_bin_checker
    import wfft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      errors,
    output int      pending
);

    localparam int NPTS = 1 << LOG2_POINTS_DEF;
    localparam int HALF_PTS = NPTS / 2;
    localparam bit [63:0] PI_Q62 = 64'hC90FDAA22168C234;

    bit [31:0] store_re [NPTS];
    bit [31:0] store_im [NPTS];
    bit [31:0] twid_re [HALF_PTS];
    bit [31:0] twid_im [HALF_PTS];
    result_t bins_due [$];

    function automatic bit [63:0] q62_mul(bit [63:0] a, bit [63:0] b);
        bit [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    function automatic bit [31:0] round_q31(bit [63:0] v);
        bit neg;
        bit [63:0] mag;
        bit [63:0] r;
        neg = v[63];
        mag = neg ? (~v + 64'd1) : v;
        r = (mag + 64'h40000000) >> 31;
        if (!neg)
        begin
            return (r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
        end
        if (r > 64'h80000000)
        begin
            r = 64'h80000000;
        end
        return 32'd0 - r[31:0];
    endfunction

    task automatic build_twiddles();
        bit [127:0] angle;
        bit [63:0] x;
        bit [63:0] term;
        bit [63:0] c;
        bit [63:0] s;
        int kk;
        for (int k = 0; k < HALF_PTS; k++)
        begin
            kk = (k < HALF_PTS / 2) ? k : k - HALF_PTS / 2;
            angle = {64'b0, PI_Q62} * kk;
            x = angle[72:9];
            term = 64'd1 << 62;
            c = term;
            s = 64'd0;
            for (int n = 1; n <= 30; n++)
            begin
                term = q62_mul(term, x) / n;
                if (n % 2 == 1)
                begin
                    s = ((n >> 1) & 1) ? s - term : s + term;
                end
                else
                begin
                    c = ((n >> 1) & 1) ? c - term : c + term;
                end
            end
            if (k < HALF_PTS / 2)
            begin
                twid_re[k] = round_q31(c);
                twid_im[k] = round_q31(64'd0 - s);
            end
            else
            begin
                twid_re[k] = round_q31(64'd0 - s);
                twid_im[k] = round_q31(64'd0 - c);
            end
        end
    endtask

    function automatic bit [31:0] twiddle_product(bit [31:0] a, bit [31:0] w);
        longint p;
        p = longint'($signed(a)) * longint'($signed(w));
        p = p >>> 31;
        return p[31:0];
    endfunction

    task automatic transform_store();
        int half;
        int groups;
        int top;
        int bot;
        int t;
        bit [31:0] pr;
        bit [31:0] pim;
        bit [31:0] ar;
        bit [31:0] ai;
        for (int st = 0; st < LOG2_POINTS_DEF; st++)
        begin
            half = 1 << st;
            groups = 1 << (LOG2_POINTS_DEF - 1 - st);
            for (int g = 0; g < groups; g++)
            begin
                for (int k = 0; k < half; k++)
                begin
                    top = g * 2 * half + k;
                    bot = top + half;
                    t = k * groups;
                    pr = twiddle_product(store_re[bot], twid_re[t])
                         - twiddle_product(store_im[bot], twid_im[t]);
                    pim = twiddle_product(store_re[bot], twid_im[t])
                          + twiddle_product(store_im[bot], twid_re[t]);
                    ar = store_re[top];
                    ai = store_im[top];
                    store_re[top] = ar + pr;
                    store_im[top] = ai + pim;
                    store_re[bot] = ar - pr;
                    store_im[bot] = ai - pim;
                end
            end
        end
    endtask

    task automatic apply_item(item_t it);
        longint p;
        bit [9:0] rev;
        result_t r;
        case (it.mode)
            MODE_LOAD:
            begin
                for (int b = 0; b < 10; b++)
                begin
                    rev[9 - b] = it.point_index[b];
                end
                p = longint'(it.sample) * 65536 * longint'({32'b0, it.window_weight});
                p = p >>> 31;
                store_re[rev] = p[31:0];
                store_im[rev] = 32'd0;
            end
            MODE_RUN:
            begin
                transform_store();
            end
            MODE_READ:
            begin
                r.bin_real = store_re[it.point_index];
                r.bin_imag = store_im[it.point_index];
                r.bin_number = it.point_index;
                bins_due.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        build_twiddles();
    end

    always @(negedge clk)
    begin
        result_t exp_bin;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                apply_item(item);
            end
            if (result_valid && !result_stall)
            begin
                if (bins_due.size() == 0)
                begin
                    $error("Unexpected result transfer for bin %0d", result.bin_number);
                    errors++;
                end
                else
                begin
                    exp_bin = bins_due.pop_front();
                    if (result.bin_real !== exp_bin.bin_real)
                    begin
                        $error("bin_real expected %0d actual %0d",
                               exp_bin.bin_real, result.bin_real);
                        errors++;
                    end
                    if (result.bin_imag !== exp_bin.bin_imag)
                    begin
                        $error("bin_imag expected %0d actual %0d",
                               exp_bin.bin_imag, result.bin_imag);
                        errors++;
                    end
                    if (result.bin_number !== exp_bin.bin_number)
                    begin
                        $error("bin_number expected %0d actual %0d",
                               exp_bin.bin_number, result.bin_number);
                        errors++;
                    end
                end
            end
            pending = bins_due.size();
        end
    end

endmodule

### verif/tb_windowed_radix2_fft_1024.sv
// Testbench top that drives load, run, read and skip transfers into the windowed FFT.
`timescale 1ns / 1ps
module tb_windowed_radix2_fft_1024;
    import wfft_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      errors;
    int      pending;
    int      sent;
    bit      calm;

    windowed_radix2_fft_1024 u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    fft_bin_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(99) < 34);
    end

    task automatic send(logic [1:0] mode, logic [9:0] idx, logic [15:0] smp, logic [31:0] w);
        bit ok;
        calm = (sent >= 400 && sent < 700);
        while (!calm && $urandom_range(99) < 34)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item.mode <= mode;
        item.point_index <= idx;
        item.sample <= smp;
        item.window_weight <= w;
        do
        begin
            @(negedge clk);
            ok = !item_stall;
            @(posedge clk);
        end
        while (!ok);
        sent++;
    endtask

    function automatic logic [31:0] random_weight();
        if ($urandom_range(99) < 85)
        begin
            return $urandom_range(32'h80000000, 0);
        end
        return $urandom;
    endfunction

    task automatic load_frame(int count);
        int order [1024];
        int j;
        int tmp;
        for (int i = 0; i < 1024; i++)
        begin
            order[i] = i;
        end
        for (int i = 1023; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 3)
            begin
                send(MODE_SKIP, 10'($urandom), 16'($urandom), $urandom);
            end
            send(MODE_LOAD, 10'(order[i]), 16'($urandom), random_weight());
        end
    endtask

    task automatic read_bins(int count);
        for (int i = 0; i < count; i++)
        begin
            send(MODE_READ, 10'($urandom), 16'($urandom), $urandom);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        sent = 0;
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(MODE_LOAD, 10'd0, 16'h8000, 32'h80000000);
        send(MODE_LOAD, 10'd1023, 16'h7FFF, 32'hFFFFFFFF);
        send(MODE_LOAD, 10'd5, 16'h0000, 32'h00000000);
        send(MODE_LOAD, 10'd512, 16'hFFFF, 32'h7FFFFFFF);
        send(MODE_SKIP, 10'h3FF, 16'hFFFF, 32'hFFFFFFFF);
        send(MODE_READ, 10'd0, 16'h0, 32'h0);
        send(MODE_READ, 10'd1023, 16'hFFFF, 32'hFFFFFFFF);
        send(MODE_READ, 10'd640, 16'h0, 32'h0);
        send(MODE_READ, 10'd1, 16'h0, 32'h0);
        send(MODE_LOAD, 10'd0, 16'h8000, 32'hFFFFFFFF);
        send(MODE_READ, 10'd0, 16'h0, 32'h0);

        load_frame(1024);
        send(MODE_RUN, 10'($urandom), 16'($urandom), $urandom);
        send(MODE_READ, 10'd0, 16'h0, 32'h0);
        send(MODE_READ, 10'd1023, 16'h0, 32'h0);
        read_bins(250);

        load_frame(300);
        send(MODE_RUN, 10'($urandom), 16'($urandom), $urandom);
        read_bins(150);
        send(MODE_RUN, 10'($urandom), 16'($urandom), $urandom);
        read_bins(10);

        item_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### windowed_radix2_fft_1024.f
+incdir+src
src/wfft_pkg.sv
src/wfft_tw_rom.sv
src/windowed_radix2_fft_1024.sv
verif/fft_bin_checker.sv
verif/tb_windowed_radix2_fft_1024.sv
